>>> rtl/pasq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pasq_pkg
// Shared types, codes and sizes of the priority aging query scheduler.
// ----------------------------------------------------------------------------
package pasq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int MAX_WORKERS_DEF = 16;

  // scheduling policies
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_PRIO = 1'b1;

  typedef enum logic [1:0] {
    CFG_POLICY = 2'd0,
    CFG_AGING  = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ACT_SUBMIT = 3'd0,
    ACT_JOIN   = 3'd1,
    ACT_DONE   = 3'd2,
    ACT_RETURN = 3'd3,
    ACT_LEAVE  = 3'd4,
    ACT_TICK   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    KIND_ID       = 3'd0,
    KIND_DISPATCH = 3'd1,
    KIND_PREEMPT  = 3'd2,
    KIND_ABORT    = 3'd3,
    KIND_UNKNOWN  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0] job;
    logic [7:0]  pri;
    logic [15:0] pc;
  } rq_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] job;
    logic [3:0]  worker;
    logic [7:0]  pri;
    logic [15:0] pc;
  } res_t;

  function automatic res_t mk_res(kind_t kind, logic [15:0] job, logic [3:0] worker,
                                  logic [7:0] pri, logic [15:0] pc);
    res_t r;
    r.kind   = kind;
    r.job    = job;
    r.worker = worker;
    r.pri    = pri;
    r.pc     = pc;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pasq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pasq_req_if
// Request channel: one scheduling event per transfer.
// ----------------------------------------------------------------------------
interface pasq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  priority_req;
  logic [3:0]  worker_num;
  logic [15:0] job_id;
  logic [15:0] program_counter;

  modport source (output valid, action, priority_req, worker_num, job_id, program_counter,
                  input ready);
  modport sink (input valid, action, priority_req, worker_num, job_id, program_counter,
                output ready);
endinterface
`default_nettype wire

>>> rtl/pasq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pasq_rsp_if
// Response channel: one scheduler result per transfer.
// ----------------------------------------------------------------------------
interface pasq_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] out_job_id;
  logic [3:0]  out_worker_id;
  logic [7:0]  out_priority;
  logic [15:0] out_counter;
  logic        last;

  modport source (output valid, kind, out_job_id, out_worker_id, out_priority,
                  out_counter, last, input ready);
  modport sink (input valid, kind, out_job_id, out_worker_id, out_priority,
                out_counter, last, output ready);
endinterface
`default_nettype wire

>>> rtl/pasq_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pasq_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface pasq_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/pasq_ready_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pasq_ready_mem
// Ready queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pasq_ready_mem
  import pasq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(QUEUE_DEPTH_DEF)
) (
  input  wire logic      clk,
  input  wire logic      we,
  input  wire logic [AW-1:0] waddr,
  input  wire rq_entry_t wdata,
  input  wire logic [AW-1:0] raddr,
  output rq_entry_t      rdata
);

  rq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/priority_aging_query_scheduler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// priority_aging_query_scheduler_unit
// Job scheduler with FIFO or priority policy, aging and preemption requests.
// ----------------------------------------------------------------------------
// One event is handled at a time; req.ready is high only while the unit waits
// for an event. Jobs waiting for a worker sit in a single-port-write RAM in
// arrival order; every pass over it visits the entries one by one. A dispatch
// scans the queued jobs for the best one (one entry for FIFO, ready_count
// entries for priority) and then closes the gap by moving the younger entries
// down one place each cycle. A tick that ages the queue sweeps every entry
// once. Lookups by job and preemption checks walk the worker table, one
// worker per cycle. Results leave through an output register, so a new event
// is taken while the last result still waits for rsp.ready. Configuration
// writes are taken at any time and are meant to be issued while the unit is
// quiet.
// ----------------------------------------------------------------------------
module priority_aging_query_scheduler_unit
  import pasq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pasq_req_if.sink   req,
  pasq_rsp_if.source rsp,
  pasq_cfg_if.sink   cfg
);

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int WIW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int WCW  = $clog2(MAX_WORKERS + 1);
  localparam logic [CNTW-1:0] QD_FULL = CNTW'(QUEUE_DEPTH);
  localparam logic [WCW-1:0]  MW_FULL = WCW'(MAX_WORKERS);
  localparam logic [WIW-1:0]  W_LAST  = WIW'(MAX_WORKERS - 1);

  typedef enum logic [12:0] {
    S_IDLE        = 13'b0000000000001,
    S_FIND        = 13'b0000000000010,
    S_SERVE       = 13'b0000000000100,
    S_PICK        = 13'b0000000001000,
    S_DISPATCH    = 13'b0000000010000,
    S_SHIFT       = 13'b0000000100000,
    S_AGE         = 13'b0000001000000,
    S_PREEMPT     = 13'b0000010000000,
    S_SUBMIT_HEAD = 13'b0000100000000,
    S_IQ_FIND     = 13'b0001000000000,
    S_IQ_SHIFT    = 13'b0010000000000,
    S_LEAVE_RUN   = 13'b0100000000000,
    S_EMIT        = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration
  logic        policy;
  logic [15:0] aging_period;
  logic [15:0] aging_ticks;

  // ready queue
  logic [CNTW-1:0] ready_count;
  logic [AW-1:0]   scan_i;
  logic [AW-1:0]   best_idx;
  rq_entry_t       best_e;
  rq_entry_t       rq_rdata;
  logic            rq_we;
  logic [AW-1:0]   rq_wa;
  logic [AW-1:0]   rq_ra;
  rq_entry_t       rq_wd;

  // worker table
  logic [MAX_WORKERS-1:0] run_valid;
  logic [MAX_WORKERS-1:0] idle_bit;
  logic [15:0]    rt_job [MAX_WORKERS];
  logic [7:0]     rt_pri [MAX_WORKERS];
  logic [WIW-1:0] rt_idx;
  logic [WIW-1:0] iq [MAX_WORKERS];
  logic [WIW-1:0] iq_idx;
  logic [WCW-1:0] idle_count;
  logic [WCW-1:0] worker_total;
  logic [15:0]    next_job_id;

  // event registers
  action_t        act_q;
  logic [15:0]    job_q;
  logic [15:0]    pc_q;
  logic [WIW-1:0] srv_w;
  logic           ret_serve;

  // preempt check
  logic [7:0]     pchk;
  logic [WCW-1:0] run_cnt;
  logic           p_found;
  logic [7:0]     worst_pri;
  logic [15:0]    worst_job;
  logic [WIW-1:0] worst_w;

  // aging sweep
  logic       age_any;
  logic [7:0] age_low;

  // results
  res_t       res [2];
  logic [1:0] res_n;
  logic       e_i;
  logic       ov;
  res_t       o_res;
  logic       o_last;

  // combinational helpers
  logic           acc;
  action_t        in_act;
  logic           w_ok;
  logic [WIW-1:0] in_w;
  logic           rq_full;
  logic           sub_push;
  logic           ret_push;
  logic [15:0]    rt_rd_job;
  logic [7:0]     rt_rd_pri;
  logic           rt_rd_v;
  logic [WIW-1:0] iq_rd;
  logic           f_hit;
  logic [15:0]    period;
  logic [15:0]    tick_nx;
  logic           p_better;
  logic [WCW-1:0] cnt_nx;
  logic           p_found_nx;
  logic [7:0]     worst_pri_nx;
  logic [15:0]    worst_job_nx;
  logic [WIW-1:0] worst_w_nx;
  logic           age_dec;
  logic [7:0]     age_pri;
  logic           age_any_nx;
  logic [7:0]     age_low_nx;
  logic           pick_better;
  logic           scan_last;

  assign acc       = req.valid && req.ready;
  assign in_act    = action_t'(req.action);
  assign w_ok      = 32'(req.worker_num) < 32'(MAX_WORKERS);
  assign in_w      = WIW'(req.worker_num);
  assign rq_full   = (ready_count == QD_FULL);
  assign rt_rd_job = rt_job[rt_idx];
  assign rt_rd_pri = rt_pri[rt_idx];
  assign rt_rd_v   = run_valid[rt_idx];
  assign iq_rd     = iq[iq_idx];
  assign f_hit     = rt_rd_v && (rt_rd_job == job_q);
  assign sub_push  = acc && (in_act == ACT_SUBMIT) && !rq_full;
  assign ret_push  = (state == S_FIND) && f_hit && (act_q == ACT_RETURN) && !rq_full;
  assign period    = (aging_period == 16'd0) ? 16'd1 : aging_period;
  assign tick_nx   = aging_ticks + 16'd1;

  // worst running job, lowest worker id wins ties
  assign p_better     = rt_rd_v && (!p_found || rt_rd_pri > worst_pri);
  assign cnt_nx       = run_cnt + WCW'(rt_rd_v);
  assign p_found_nx   = p_found || rt_rd_v;
  assign worst_pri_nx = p_better ? rt_rd_pri : worst_pri;
  assign worst_job_nx = p_better ? rt_rd_job : worst_job;
  assign worst_w_nx   = p_better ? rt_idx : worst_w;

  assign age_dec    = (rq_rdata.pri != 8'd0);
  assign age_pri    = rq_rdata.pri - 8'd1;
  assign age_any_nx = age_any || age_dec;
  assign age_low_nx = (age_dec && (!age_any || age_pri < age_low)) ? age_pri : age_low;

  assign pick_better = (scan_i == '0) || (rq_rdata.pri < best_e.pri);
  assign scan_last   = (CNTW'(scan_i) == ready_count - CNTW'(1));

  // ready queue ports
  always_comb begin
    rq_we = 1'b0;
    rq_wa = scan_i;
    rq_wd = rq_rdata;
    if (sub_push) begin
      rq_we = 1'b1;
      rq_wa = AW'(ready_count);
      rq_wd = '{job: next_job_id, pri: req.priority_req, pc: 16'd0};
    end else if (ret_push) begin
      rq_we = 1'b1;
      rq_wa = AW'(ready_count);
      rq_wd = '{job: job_q, pri: rt_rd_pri, pc: pc_q};
    end else if (state == S_SHIFT) begin
      rq_we = 1'b1;
      rq_wa = scan_i - AW'(1);
    end else if (state == S_AGE) begin
      rq_we = 1'b1;
      if (age_dec) begin
        rq_wd.pri = age_pri;
      end
    end
  end

  always_comb begin
    unique case (state)
      S_PICK, S_SHIFT, S_AGE: rq_ra = scan_i + AW'(1);
      S_DISPATCH:             rq_ra = best_idx + AW'(1);
      default:                rq_ra = '0;
    endcase
  end

  pasq_ready_mem #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_ready_mem (
    .clk  (clk),
    .we   (rq_we),
    .waddr(rq_wa),
    .wdata(rq_wd),
    .raddr(rq_ra),
    .rdata(rq_rdata)
  );

  // worker table payload
  always_ff @(posedge clk) begin
    if (state == S_DISPATCH) begin
      rt_job[srv_w] <= best_e.job;
      rt_pri[srv_w] <= best_e.pri;
    end
    if (state == S_IQ_SHIFT) begin
      iq[iq_idx - WIW'(1)] <= iq_rd;
    end else if (state == S_SERVE && ready_count == '0 && idle_count < MW_FULL) begin
      iq[WIW'(idle_count)] <= srv_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      policy       <= POLICY_FIFO;
      aging_period <= 16'd1;
      aging_ticks  <= '0;
      ready_count  <= '0;
      run_valid    <= '0;
      idle_bit     <= '0;
      idle_count   <= '0;
      worker_total <= '0;
      next_job_id  <= '0;
      res_n        <= '0;
      e_i          <= 1'b0;
      ov           <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_index_t'(cfg.index))
          CFG_POLICY: policy <= cfg.data[0];
          CFG_AGING:  aging_period <= cfg.data;
          default: ;
        endcase
      end
      // a result loaded this cycle keeps the output register full
      if (ov && rsp.ready && !(state == S_EMIT && res_n != 2'd0)) begin
        ov <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (acc) begin
            act_q <= in_act;
            job_q <= req.job_id;
            pc_q  <= req.program_counter;
            unique case (in_act)
              ACT_SUBMIT: begin
                next_job_id <= next_job_id + 16'd1;
                res[0] <= mk_res(KIND_ID, next_job_id, 4'd0, req.priority_req, 16'd0);
                if (idle_count != '0) begin
                  res_n  <= 2'd1;
                  if (!rq_full) begin
                    ready_count <= ready_count + CNTW'(1);
                  end
                  iq_idx <= '0;
                  state  <= S_SUBMIT_HEAD;
                end else if (rq_full) begin
                  res[1] <= mk_res(KIND_ABORT, next_job_id, 4'd0, req.priority_req, 16'd0);
                  res_n  <= 2'd2;
                  state  <= S_EMIT;
                end else begin
                  ready_count <= ready_count + CNTW'(1);
                  res_n <= 2'd1;
                  if (policy == POLICY_PRIO) begin
                    pchk    <= req.priority_req;
                    rt_idx  <= '0;
                    run_cnt <= '0;
                    p_found <= 1'b0;
                    state   <= S_PREEMPT;
                  end else begin
                    state <= S_EMIT;
                  end
                end
              end
              ACT_JOIN: begin
                if (w_ok && !run_valid[in_w] && !idle_bit[in_w]) begin
                  worker_total <= worker_total + WCW'(1);
                  srv_w <= in_w;
                  state <= S_SERVE;
                end
              end
              ACT_DONE, ACT_RETURN: begin
                rt_idx <= '0;
                state  <= S_FIND;
              end
              ACT_LEAVE: begin
                if (w_ok) begin
                  if (idle_bit[in_w]) begin
                    idle_bit[in_w] <= 1'b0;
                    srv_w  <= in_w;
                    iq_idx <= '0;
                    if (worker_total != '0) begin
                      worker_total <= worker_total - WCW'(1);
                    end
                    state <= S_IQ_FIND;
                  end else if (run_valid[in_w]) begin
                    run_valid[in_w] <= 1'b0;
                    rt_idx <= in_w;
                    if (worker_total != '0) begin
                      worker_total <= worker_total - WCW'(1);
                    end
                    state <= S_LEAVE_RUN;
                  end
                end
              end
              ACT_TICK: begin
                if (policy == POLICY_PRIO) begin
                  if (tick_nx < period) begin
                    aging_ticks <= tick_nx;
                  end else begin
                    aging_ticks <= '0;
                    if (ready_count != '0) begin
                      scan_i  <= '0;
                      age_any <= 1'b0;
                      state   <= S_AGE;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_FIND: begin
          if (f_hit) begin
            run_valid[rt_idx] <= 1'b0;
            srv_w <= rt_idx;
            if (act_q == ACT_RETURN) begin
              if (!rq_full) begin
                ready_count <= ready_count + CNTW'(1);
              end else begin
                res[res_n[0]] <= mk_res(KIND_ABORT, job_q, 4'd0, rt_rd_pri, pc_q);
                res_n <= res_n + 2'd1;
              end
            end
            state <= S_SERVE;
          end else if (rt_idx == W_LAST) begin
            res[res_n[0]] <= mk_res(KIND_UNKNOWN, job_q, 4'd0, 8'd0, 16'd0);
            res_n <= res_n + 2'd1;
            state <= S_EMIT;
          end else begin
            rt_idx <= rt_idx + WIW'(1);
          end
        end

        S_SERVE: begin
          if (ready_count == '0) begin
            if (idle_count < MW_FULL) begin
              idle_count      <= idle_count + WCW'(1);
              idle_bit[srv_w] <= 1'b1;
            end
            state <= S_EMIT;
          end else begin
            scan_i <= '0;
            state  <= S_PICK;
          end
        end

        S_PICK: begin
          if (pick_better) begin
            best_e   <= rq_rdata;
            best_idx <= scan_i;
          end
          if (policy == POLICY_FIFO || scan_last) begin
            state <= S_DISPATCH;
          end else begin
            scan_i <= scan_i + AW'(1);
          end
        end

        S_DISPATCH: begin
          run_valid[srv_w] <= 1'b1;
          res[res_n[0]] <= mk_res(KIND_DISPATCH, best_e.job, 4'(srv_w), best_e.pri,
                                  best_e.pc);
          res_n <= res_n + 2'd1;
          if (CNTW'(best_idx) == ready_count - CNTW'(1)) begin
            ready_count <= ready_count - CNTW'(1);
            state <= S_EMIT;
          end else begin
            scan_i <= best_idx + AW'(1);
            state  <= S_SHIFT;
          end
        end

        S_SHIFT: begin
          // entry scan_i moves down one place
          if (scan_last) begin
            ready_count <= ready_count - CNTW'(1);
            state <= S_EMIT;
          end else begin
            scan_i <= scan_i + AW'(1);
          end
        end

        S_AGE: begin
          age_any <= age_any_nx;
          age_low <= age_low_nx;
          if (scan_last) begin
            if (age_any_nx) begin
              pchk    <= age_low_nx;
              rt_idx  <= '0;
              run_cnt <= '0;
              p_found <= 1'b0;
              state   <= S_PREEMPT;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            scan_i <= scan_i + AW'(1);
          end
        end

        S_PREEMPT: begin
          run_cnt   <= cnt_nx;
          p_found   <= p_found_nx;
          worst_pri <= worst_pri_nx;
          worst_job <= worst_job_nx;
          worst_w   <= worst_w_nx;
          if (rt_idx == W_LAST) begin
            if (p_found_nx && cnt_nx == worker_total && pchk < worst_pri_nx) begin
              res[res_n[0]] <= mk_res(KIND_PREEMPT, worst_job_nx, 4'(worst_w_nx),
                                      worst_pri_nx, 16'd0);
              res_n <= res_n + 2'd1;
            end
            state <= S_EMIT;
          end else begin
            rt_idx <= rt_idx + WIW'(1);
          end
        end

        S_SUBMIT_HEAD: begin
          srv_w <= iq_rd;
          idle_bit[iq_rd] <= 1'b0;
          if (idle_count == WCW'(1)) begin
            idle_count <= '0;
            state <= S_SERVE;
          end else begin
            iq_idx    <= WIW'(1);
            ret_serve <= 1'b1;
            state     <= S_IQ_SHIFT;
          end
        end

        S_IQ_FIND: begin
          if (iq_rd == srv_w) begin
            if (WCW'(iq_idx) == idle_count - WCW'(1)) begin
              idle_count <= idle_count - WCW'(1);
              state <= S_EMIT;
            end else begin
              iq_idx    <= iq_idx + WIW'(1);
              ret_serve <= 1'b0;
              state     <= S_IQ_SHIFT;
            end
          end else begin
            iq_idx <= iq_idx + WIW'(1);
          end
        end

        S_IQ_SHIFT: begin
          if (WCW'(iq_idx) == idle_count - WCW'(1)) begin
            idle_count <= idle_count - WCW'(1);
            state <= ret_serve ? S_SERVE : S_EMIT;
          end else begin
            iq_idx <= iq_idx + WIW'(1);
          end
        end

        S_LEAVE_RUN: begin
          res[res_n[0]] <= mk_res(KIND_ABORT, rt_rd_job, 4'(rt_idx), rt_rd_pri, 16'd0);
          res_n <= res_n + 2'd1;
          state <= S_EMIT;
        end

        S_EMIT: begin
          if (res_n == 2'd0) begin
            state <= S_IDLE;
          end else if (!ov || rsp.ready) begin
            ov     <= 1'b1;
            o_res  <= res[e_i];
            o_last <= ({1'b0, e_i} == res_n - 2'd1);
            if ({1'b0, e_i} == res_n - 2'd1) begin
              e_i   <= 1'b0;
              res_n <= 2'd0;
              state <= S_IDLE;
            end else begin
              e_i <= 1'b1;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready         = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign rsp.valid         = ov;
  assign rsp.kind          = o_res.kind;
  assign rsp.out_job_id    = o_res.job;
  assign rsp.out_worker_id = o_res.worker;
  assign rsp.out_priority  = o_res.pri;
  assign rsp.out_counter   = o_res.pc;
  assign rsp.last          = o_last;

  // a worker is never both idle and running
  a_idle_run_excl: assert property (@(posedge clk) disable iff (rst)
    $countones(run_valid & idle_bit) == 0)
    else $error("worker both idle and running");

  // idle workers only while nothing waits, checked in S_IDLE
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (idle_count == '0 || ready_count == '0))
    else $error("idle worker while jobs wait");

  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    ready_count <= QD_FULL)
    else $error("ready queue overflow");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_n <= 2'd2)
    else $error("result buffer overflow");

endmodule
`default_nettype wire
